// File: rtl/core/sorted_table_search_delete_edit_core_defines.svh
// Assertion macros shared by the sorted table core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_TABLE_SEARCH_DELETE_EDIT_CORE_DEFINES_SVH
`define SORTED_TABLE_SEARCH_DELETE_EDIT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sts_pkg.sv
// Shared types and codes for the sorted table core.
// No dependencies.
package sts_pkg;

  localparam int CMD_W   = 3;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EDIT   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;

  // Broadcast operation for the row of cells.
  typedef struct packed {
    logic rotate;     // every cell takes its right neighbor (ring)
    logic close_gap;  // cells at or past the first match take right neighbor
    logic insert;     // sorted insert of the broadcast value
  } cell_ctl_t;

  typedef struct packed {
    logic              found;
    logic [3:0]        first_position;
    logic [4:0]        match_count;
    logic [4:0]        entry_count;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

// File: rtl/core/sts_cell.sv
// One storage cell of the sorted row: holds one entry, shifts with neighbors.
// Depends on sts_pkg.
module sts_cell
  import sts_pkg::*;
#(
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  word_t         ins_val,
  input  word_t         from_next,
  input  word_t         from_prev,
  input  logic          prev_below,
  input  logic [IW-1:0] idx,
  input  logic [CW-1:0] cnt,
  input  logic [IW-1:0] first,
  output word_t         val,
  output logic          below
);

  word_t val_r;
  word_t val_nxt;

  // Valid entry strictly below the broadcast value.
  assign below = (CW'(idx) < cnt) && (val_r < ins_val);
  assign val   = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.rotate) begin
      val_nxt = from_next;
    end else if (ctl.close_gap && (idx >= first)) begin
      val_nxt = from_next;
    end else if (ctl.insert && !below) begin
      val_nxt = prev_below ? ins_val : from_prev;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: rtl/core/sts_ctrl.sv
// Command sequencer: lookup sweep over the rotating row, then shift steps.
// Depends on sts_pkg and the shared assertion macro header.
`include "sorted_table_search_delete_edit_core_defines.svh"
module sts_ctrl
  import sts_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] cmd,
  input  word_t            key,
  input  word_t            nv,
  input  word_t            head,
  output cell_ctl_t        ctl,
  output word_t            ins_val,
  output logic [CW-1:0]    cnt,
  output logic [IW-1:0]    first,
  output logic             res_valid,
  output result_t          res
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_DISP  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FILL  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  word_t            key_r, key_nxt;
  word_t            nv_r, nv_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    first_r, first_nxt;
  logic [CW-1:0]    match_r, match_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    step_r, step_nxt;
  logic             res_valid_r, res_valid_nxt;
  result_t          res_r, res_nxt;

  logic             finish;
  logic [STAT_W-1:0] stat;
  logic             found;
  logic             known_cmd;

  assign busy      = (state_r != S_IDLE);
  assign cnt       = cnt_r;
  assign first     = first_r;
  assign ins_val   = (state_r == S_FILL) ? nv_r : key_r;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign found     = (match_r != '0);
  assign known_cmd = (cmd_r <= CMD_EDIT);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    nv_nxt    = nv_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    match_nxt = match_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    ctl       = '0;
    finish    = 1'b0;
    stat      = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd;
          key_nxt   = key;
          nv_nxt    = nv;
          idx_nxt   = '0;
          first_nxt = '0;
          match_nxt = '0;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        // head holds entry idx_r; a full turn restores the row
        ctl.rotate = 1'b1;
        if ((CW'(idx_r) < cnt_r) && (head == key_r)) begin
          if (match_r == '0) begin
            first_nxt = idx_r;
          end
          match_nxt = match_r + CW'(1);
        end
        idx_nxt = idx_r + IW'(1);
        if (idx_r == IW'(DEPTH - 1)) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_r)
          CMD_CLEAR: begin
            cnt_nxt = '0;
            finish  = 1'b1;
          end
          CMD_INSERT: begin
            if (cnt_r >= CW'(DEPTH)) begin
              stat = ST_FULL;
            end else begin
              ctl.insert = 1'b1;
              cnt_nxt    = cnt_r + CW'(1);
            end
            finish = 1'b1;
          end
          CMD_SEARCH: begin
            if (!found) begin
              stat = ST_NOT_FOUND;
            end
            finish = 1'b1;
          end
          CMD_DELETE, CMD_EDIT: begin
            if (!found) begin
              stat   = ST_NOT_FOUND;
              finish = 1'b1;
            end else begin
              step_nxt  = match_r;
              state_nxt = S_SHIFT;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_SHIFT: begin
        // one copy removed per cycle
        ctl.close_gap = 1'b1;
        step_nxt      = step_r - CW'(1);
        if (step_r == CW'(1)) begin
          cnt_nxt = cnt_r - match_r;
          if (cmd_r == CMD_EDIT) begin
            step_nxt  = match_r;
            state_nxt = S_FILL;
          end else begin
            finish = 1'b1;
          end
        end
      end
      S_FILL: begin
        // one copy of the new value inserted per cycle
        ctl.insert = 1'b1;
        cnt_nxt    = cnt_r + CW'(1);
        step_nxt   = step_r - CW'(1);
        if (step_r == CW'(1)) begin
          finish = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = S_IDLE;
    end

    res_valid_nxt          = finish;
    res_nxt                = res_r;
    if (finish) begin
      res_nxt.found          = found && known_cmd;
      res_nxt.first_position = (found && known_cmd) ? 4'(first_r) : 4'd0;
      res_nxt.match_count    = known_cmd ? 5'(match_r) : 5'd0;
      res_nxt.entry_count    = 5'(cnt_nxt);
      res_nxt.status         = stat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    nv_r    <= nv_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    match_r <= match_nxt;
    step_r  <= step_nxt;
    res_r   <= res_nxt;
  end

  `STS_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(DEPTH), "entry count past depth")
  `STS_ASSERT_NEXT(a_start_look, clk, rst_n, start && !busy, state_r == S_LOOK, "start not taken")
  `STS_ASSERT_NOW(a_res_after_work, clk, rst_n, res_valid_r, !$past(state_r == S_IDLE), "stray result")
  `STS_ASSERT_NOW(a_step_live, clk, rst_n, state_r == S_SHIFT || state_r == S_FILL, step_r != '0, "zero step")

endmodule

// File: rtl/core/sorted_table_search_delete_edit_core.sv
// Top level of the sorted table core: row of storage cells plus sequencer.
// Depends on sts_pkg, sts_cell and sts_ctrl.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  request  | start / busy        | in_cmd, in_key_value, in_new_value
//  result   | out_valid (strobe)  | out_found, out_first_position,
//           |                     | out_match_count, out_entry_count, out_status
//
// Steps: a request first runs a lookup (the row turns once past the head
//   cell), then a dispatch step; delete then shifts the row once per matching
//   copy, edit shifts out each copy and then inserts the new value once per
//   copy. Clear, insert and search finish at the dispatch step.
// The result strobe is registered and rises as the last step ends; busy falls on the
//   same edge, so the next request may be given while the strobe is high.
// Reset clears the entry count and the sequencer; cell contents are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_table_search_delete_edit_core
  import sts_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [WORD_W-1:0] in_key_value,
  input  logic signed [WORD_W-1:0] in_new_value,
  output logic                     out_valid,
  output logic                     out_found,
  output logic [3:0]               out_first_position,
  output logic [4:0]               out_match_count,
  output logic [4:0]               out_entry_count,
  output logic [STAT_W-1:0]        out_status
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cell_ctl_t     ctl;
  word_t         ins_val;
  logic [CW-1:0] cnt;
  logic [IW-1:0] first;
  result_t       res;

  // cell values and insert flags along the row
  word_t         val   [DEPTH];
  logic          below [DEPTH];

  sts_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (in_cmd),
    .key       (in_key_value),
    .nv        (in_new_value),
    .head      (val[0]),
    .ctl       (ctl),
    .ins_val   (ins_val),
    .cnt       (cnt),
    .first     (first),
    .res_valid (out_valid),
    .res       (res)
  );

  // Cell 0 is the head: the lookup reads it, insert enters there when the
  // new value is the smallest. The last cell wraps to the head so a full
  // rotation leaves the row unchanged.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t prev_val;
    logic  prev_flag;

    if (i == 0) begin : g_head
      assign prev_val  = '0;
      assign prev_flag = 1'b1;
    end else begin : g_body
      assign prev_val  = val[i-1];
      assign prev_flag = below[i-1];
    end

    sts_cell #(
      .IW (IW),
      .CW (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_val    (ins_val),
      .from_next  (val[(i + 1) % DEPTH]),
      .from_prev  (prev_val),
      .prev_below (prev_flag),
      .idx        (IW'(i)),
      .cnt        (cnt),
      .first      (first),
      .val        (val[i]),
      .below      (below[i])
    );
  end

  assign out_found          = res.found;
  assign out_first_position = res.first_position;
  assign out_match_count    = res.match_count;
  assign out_entry_count    = res.entry_count;
  assign out_status         = res.status;

endmodule

// File: sim/tb_top.sv
// Self-checking bench for the sorted table core: directed table, then random requests.
// Depends on sts_pkg and sorted_table_search_delete_edit_core.
// A queue-based table model in the bench predicts every result; typed rows use their hand-written expectation.
`timescale 1ns / 100ps

module tb_top;
  import sts_pkg::*;

  localparam int    TBL_DEPTH    = 16;
  localparam int    RANDOM_ITEMS = 340;
  // Worst request is an edit of a full run. Gaps are short.
  localparam int    QUIET_LIMIT  = 2000;
  localparam int    TAIL_CYCLES  = 4 * TBL_DEPTH;
  localparam int    MAX_REPORTS  = 40;
  localparam word_t W_MIN        = 32'sh8000_0000;
  localparam word_t W_MAX        = 32'sh7FFF_FFFF;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd;
  word_t             in_key_value;
  word_t             in_new_value;
  logic              out_valid;
  logic              out_found;
  logic [3:0]        out_first_position;
  logic [4:0]        out_match_count;
  logic [4:0]        out_entry_count;
  logic [STAT_W-1:0] out_status;

  sorted_table_search_delete_edit_core #(
    .DEPTH(TBL_DEPTH)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_key_value      (in_key_value),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_first_position(out_first_position),
    .out_match_count   (out_match_count),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Table model: the queue always holds the valid entries in ascending order.
  // ---------------------------------------------------------------------------
  word_t   sorted_vals[$];
  result_t pending_results[$];   // expected results, oldest first
  int      mismatches = 0;
  int      idle_pct   = 23;      // sender idle chance per cycle, in percent
  int      quiet_cycles = 0;

  // Number of entries strictly below v, i.e. the sorted insert slot.
  function automatic int slot_below(input word_t v);
    int n;
    n = 0;
    foreach (sorted_vals[i])
      if (sorted_vals[i] < v) n++;
    return n;
  endfunction

  // Applies one request to the model table and returns the result it should give.
  function automatic result_t table_update(input logic [CMD_W-1:0] cmd, input word_t key,
                                           input word_t nv);
    result_t r;
    int      first;
    int      hits;
    int      pos;
    r     = '0;
    first = 0;
    hits  = 0;
    // Lookup happens on the table as it stands before the request.
    foreach (sorted_vals[i])
      if (sorted_vals[i] == key) begin
        if (hits == 0) first = i;
        hits++;
      end
    r.status = ST_OK;
    case (cmd)
      CMD_CLEAR: sorted_vals.delete();
      CMD_INSERT: begin
        if (sorted_vals.size() >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = slot_below(key);
          sorted_vals.insert(pos, key);
        end
      end
      CMD_SEARCH: if (hits == 0) r.status = ST_NOT_FOUND;
      CMD_DELETE: begin
        if (hits == 0) r.status = ST_NOT_FOUND;
        else repeat (hits) sorted_vals.delete(first);   // copies form one run
      end
      CMD_EDIT: begin
        if (hits == 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          repeat (hits) sorted_vals.delete(first);
          pos = slot_below(nv);
          repeat (hits) sorted_vals.insert(pos, nv);
        end
      end
      default: begin
        // unused codes leave the table alone and report no lookup
        hits  = 0;
        first = 0;
      end
    endcase
    r.found          = (hits != 0);
    r.first_position = (hits != 0) ? first[3:0] : 4'd0;
    r.match_count    = hits[4:0];
    r.entry_count    = 5'(sorted_vals.size());
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed = 1 carry a hand-written expectation.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [CMD_W-1:0] cmd;
    word_t            key;
    word_t            nv;
    int               rep;
    bit               typed;
    result_t          want;
  } plan_row_t;

  plan_row_t plan[$];

  task automatic add_row(input logic [CMD_W-1:0] cmd, input word_t key, input word_t nv,
                         input int rep, input bit typed, input logic f, input logic [3:0] p,
                         input logic [4:0] m, input logic [4:0] e, input logic [STAT_W-1:0] s);
    plan_row_t row;
    row.cmd   = cmd;
    row.key   = key;
    row.nv    = nv;
    row.rep   = rep;
    row.typed = typed;
    row.want  = '{found: f, first_position: p, match_count: m, entry_count: e, status: s};
    plan.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // Random picks: values lean on a small pool and on live entries so that
  // duplicates, hits and full tables are common.
  // ---------------------------------------------------------------------------
  function automatic word_t pick_value();
    int    sel;
    word_t v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = word_t'($urandom_range(6)) - 3;
    end else if (sel < 60 && sorted_vals.size() != 0) begin
      v = sorted_vals[$urandom_range(sorted_vals.size() - 1)];
    end else if (sel < 70) begin
      case ($urandom_range(5))
        0:       v = W_MIN;
        1:       v = W_MAX;
        2:       v = W_MIN + 1;
        3:       v = W_MAX - 1;
        4:       v = -1;
        default: v = 0;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int sel;
    sel = $urandom_range(99);
    if (sel < 48)      return CMD_INSERT;
    else if (sel < 62) return CMD_SEARCH;
    else if (sel < 74) return CMD_DELETE;
    else if (sel < 89) return CMD_EDIT;
    else if (sel < 93) return CMD_CLEAR;
    else               return CMD_W'($urandom_range(7, 5));   // unused codes
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at the falling edge after the
  // request was taken. start stays high into the next request unless we idle.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [CMD_W-1:0] cmd, input word_t key, input word_t nv,
                              input bit typed, input result_t want);
    result_t model_res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= cmd;
    in_key_value <= key;
    in_new_value <= nv;
    @(posedge clk);
    while (busy) @(posedge clk);
    // taken at this edge: the model advances in request order
    model_res = table_update(cmd, key, nv);
    pending_results.push_back(typed ? want : model_res);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual found=%0d entries=%0d",
                   $time, out_found, out_entry_count);
      end else begin
        want = pending_results.pop_front();
        check_field("found",          32'(want.found),          32'(out_found));
        check_field("first_position", 32'(want.first_position), 32'(out_first_position));
        check_field("match_count",    32'(want.match_count),    32'(out_match_count));
        check_field("entry_count",    32'(want.entry_count),    32'(out_entry_count));
        check_field("status",         32'(want.status),         32'(out_status));
      end
    end
  end

  // Watchdog: too long without any request or result taken means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    result_t none;
    none         = '0;
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_CLEAR;
    in_key_value = '0;
    in_new_value = '0;

    // Empty table first, then extremes, duplicates, unused codes.
    add_row(CMD_CLEAR,  0,     0,     1, 1, 0, 0, 0, 0, ST_OK);
    add_row(CMD_SEARCH, 0,     0,     1, 1, 0, 0, 0, 0, ST_NOT_FOUND);
    add_row(CMD_DELETE, W_MIN, 0,     1, 1, 0, 0, 0, 0, ST_NOT_FOUND);
    add_row(CMD_EDIT,   W_MAX, 0,     1, 1, 0, 0, 0, 0, ST_NOT_FOUND);
    add_row(CMD_INSERT, 0,     W_MAX, 1, 1, 0, 0, 0, 1, ST_OK);
    add_row(CMD_INSERT, W_MIN, 0,     1, 1, 0, 0, 0, 2, ST_OK);
    add_row(CMD_INSERT, W_MAX, W_MIN, 1, 1, 0, 0, 0, 3, ST_OK);
    add_row(CMD_INSERT, 0,     -1,    1, 1, 1, 1, 1, 4, ST_OK);    // duplicate
    add_row(CMD_SEARCH, W_MAX, 0,     1, 1, 1, 3, 1, 4, ST_OK);
    add_row(CMD_SEARCH, -1,    0,     1, 1, 0, 0, 0, 4, ST_NOT_FOUND);
    add_row(3'd5,       0,     0,     1, 1, 0, 0, 0, 4, ST_OK);    // unused code
    add_row(3'd7,       W_MAX, -1,    1, 1, 0, 0, 0, 4, ST_OK);    // unused code
    add_row(CMD_EDIT,   0,     W_MAX, 1, 0, 0, 0, 0, 0, ST_OK);
    add_row(CMD_EDIT,   W_MAX, W_MIN, 1, 0, 0, 0, 0, 0, ST_OK);
    add_row(CMD_DELETE, W_MIN, 0,     1, 0, 0, 0, 0, 0, ST_OK);    // empties the table
    // Fill with one value, then hit the full table.
    add_row(CMD_INSERT, -5,    0,     TBL_DEPTH, 0, 0, 0, 0, 0, ST_OK);
    add_row(CMD_INSERT, -5,    0,     1, 1, 1, 0, 16, 16, ST_FULL);
    add_row(CMD_INSERT, 7,     0,     1, 1, 0, 0, 0, 16, ST_FULL);
    add_row(CMD_SEARCH, -5,    0,     1, 1, 1, 0, 16, 16, ST_OK);
    add_row(CMD_EDIT,   -5,    3,     1, 0, 0, 0, 0, 0, ST_OK);    // every entry moves
    add_row(CMD_DELETE, 3,     0,     1, 0, 0, 0, 0, 0, ST_OK);
    add_row(CMD_INSERT, 5,     0,     1, 0, 0, 0, 0, 0, ST_OK);
    add_row(CMD_INSERT, 1,     0,     1, 0, 0, 0, 0, 0, ST_OK);
    add_row(CMD_INSERT, 3,     0,     1, 0, 0, 0, 0, 0, ST_OK);
    add_row(CMD_EDIT,   5,     -7,    1, 0, 0, 0, 0, 0, ST_OK);    // moves to the front
    add_row(CMD_CLEAR,  1,     0,     1, 0, 0, 0, 0, 0, ST_OK);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      repeat (plan[i].rep) send_request(plan[i].cmd, plan[i].key, plan[i].nv,
                                        plan[i].typed, plan[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // no idling on the sender for a stretch in the middle
      idle_pct = (n >= 200 && n < 300) ? 0 : 23;
      if (n % 100 == 50) begin
        // hold off until the core has drained every request
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      if (n % 60 == 0) begin
        // insert run that usually ends on a full table
        repeat (TBL_DEPTH + 2) send_request(CMD_INSERT, pick_value(), pick_value(), 0, none);
      end
      send_request(pick_cmd(), pick_value(), pick_value(), 0, none);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
